>>> design/clir_pkg.sv
package clir_pkg;

  // Request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Result status codes
  localparam logic [1:0] STAT_DONE     = 2'd0;
  localparam logic [1:0] STAT_NO_MATCH = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] entry_count;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_SHIFT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;      // capture request
    logic       idx_clr;   // idx <= 0, read entry 0
    logic       idx_inc;   // idx <= idx + 1, read entry idx + 1
    logic       wr_tail;   // write request value at the tail
    logic       wr_shift;  // write read data one place toward the head
    logic       respond;   // emit a result beat
    logic [1:0] status;
    logic       occ_inc;
    logic       occ_dec;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
    logic hit;   // read data equals the request value
    logic last;  // current index is the last held entry
  } stat_t;

endpackage

>>> design/clir_ctrl.sv
module clir_ctrl
  import clir_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output logic  busy,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.is_remove && !stat.empty) state_nxt = S_SCAN;
        else                               state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (stat.hit) state_nxt = stat.last ? S_IDLE : S_SHIFT;
        else if (stat.last) state_nxt = S_IDLE;
      end
      S_SHIFT: begin
        if (stat.last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        cmd.load = start;
      end
      S_CHECK: begin
        if (!stat.is_remove) begin
          cmd.respond = 1'b1;
          if (stat.full) begin
            cmd.status = STAT_FULL;
          end else begin
            cmd.status  = STAT_DONE;
            cmd.wr_tail = 1'b1;
            cmd.occ_inc = 1'b1;
          end
        end else if (stat.empty) begin
          cmd.respond = 1'b1;
          cmd.status  = STAT_NO_MATCH;
        end else begin
          cmd.idx_clr = 1'b1;
        end
      end
      S_SCAN: begin
        if (stat.last) begin
          cmd.respond = 1'b1;
          cmd.status  = stat.hit ? STAT_DONE : STAT_NO_MATCH;
          cmd.occ_dec = stat.hit;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.wr_shift = 1'b1;
        if (stat.last) begin
          cmd.respond = 1'b1;
          cmd.status  = STAT_DONE;
          cmd.occ_dec = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

>>> design/clir_datapath.sv
module clir_datapath
  import clir_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  input  req_t  in_req,
  input  cmd_t  cmd,
  output stat_t stat,
  output logic  out_valid,
  output rsp_t  out_rsp
);

  localparam int IW = $clog2(CAPACITY);
  localparam int OW = $clog2(CAPACITY + 1);

  logic [31:0]   entry_mem [CAPACITY];
  logic [31:0]   rd_data_r;
  logic [31:0]   val_r;
  logic          kind_r;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [OW-1:0] occ_r, occ_nxt;
  logic [OW-1:0] idx_ext;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          wr_en;
  logic          out_valid_r;
  rsp_t          out_rsp_r;

  assign idx_ext = OW'(idx_r) + OW'(1);

  always_comb begin
    idx_nxt = idx_r;
    rd_addr = '0;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
      rd_addr = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_ext[IW-1:0];
      rd_addr = idx_ext[IW-1:0];
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (cmd.occ_inc)      occ_nxt = occ_r + OW'(1);
    else if (cmd.occ_dec) occ_nxt = occ_r - OW'(1);
  end

  assign wr_en   = cmd.wr_tail || cmd.wr_shift;
  assign wr_addr = cmd.wr_tail ? occ_r[IW-1:0] : (idx_r - IW'(1));
  assign wr_data = cmd.wr_tail ? val_r : rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) entry_mem[wr_addr] <= wr_data;
    rd_data_r <= entry_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_req.req_type;
      val_r  <= in_req.value;
    end
    idx_r <= idx_nxt;
    if (cmd.respond) begin
      out_rsp_r.status      <= cmd.status;
      out_rsp_r.entry_count <= 5'(occ_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= cmd.respond;
    end
  end

  assign stat.is_remove = (kind_r == REQ_REMOVE);
  assign stat.full      = (occ_r == OW'(CAPACITY));
  assign stat.empty     = (occ_r == '0);
  assign stat.hit       = (rd_data_r == val_r);
  assign stat.last      = (idx_ext >= occ_r);

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

>>> design/circular_list_insert_remove_core.sv
// Channel   Ports                  Handshake
// request   start, busy, in_req    beat taken when start && !busy
// result    out_valid, out_rsp     one-cycle strobe, receiver always takes it
//
// Insert: busy only to check; result strobe in the first cycle with busy low.
// Remove: busy to check, then to visit each held entry (check only if empty);
//   the single memory read port visits one entry per cycle, first scanning for
//   the match, then moving each later entry one place toward the head.
// Reset (rst_n low, synchronous) empties the list; entry storage is not cleared.
// The result side never stalls, so a new request may start as the strobe shows.
module circular_list_insert_remove_core
  import clir_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  req_t in_req,
  output logic out_valid,
  output rsp_t out_rsp
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: accept, dispatch, scan, shift
  clir_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Entry store, occupancy, compare and result register
  clir_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  // Accepted beat always moves the sequencer out of idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // One result per request, never two strobes in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  // A dropped insert reports a full store
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status == STAT_FULL |-> out_rsp.entry_count == 5'(CAPACITY))
    else $error("full status with count below capacity");

endmodule
